@@ design/ncc_pkg.sv @@
// ---------------------------------------------------------------------------
// ncc_pkg: shared types and constants of the chromaticity classifier
// Field widths, register indexes, status codes and the reference entry layout.
// ---------------------------------------------------------------------------
`default_nettype none

package ncc_pkg;

   localparam int REF_DEPTH    = 16;
   localparam int CHANNEL_BITS = 16;

   localparam int REF_IDX_W  = $clog2(REF_DEPTH);
   localparam int COUNT_W    = 5;
   localparam int FIELD_W    = 16;
   localparam int SUM_W      = CHANNEL_BITS + 2;
   localparam int CHROMA_W   = 17;
   localparam int DIV_STEP_W = $clog2(CHROMA_W);
   localparam int DIST_W     = 34;
   localparam int CLASS_W    = 5;
   localparam int STATUS_W   = 2;

   localparam int ABS_W      = 17;
   localparam int RATIO_W    = 16;
   localparam int RATIO_FRAC = 12;
   localparam int MUL_A_W    = 2 * RATIO_FRAC;
   localparam int MUL_B_W    = CHROMA_W;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int SPLIT_W    = 17;
   localparam int WIDE_W     = PROD_W + SPLIT_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ABS_MAX_DIST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_MAX    = 2'd2;

   localparam logic ACTION_LOAD     = 1'b0;
   localparam logic ACTION_CLASSIFY = 1'b1;

   localparam logic [DIST_W-1:0]         DIST_INF       = '1;
   localparam logic signed [CLASS_W-1:0] NO_MATCH_INDEX = -5'sd1;
   localparam logic [RATIO_W-1:0]        RATIO_ONE      = RATIO_W'(1 << RATIO_FRAC);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MATCH     = 2'd0,
      STATUS_NO_REF    = 2'd1,
      STATUS_NO_RUNNER = 2'd2,
      STATUS_LIMIT     = 2'd3
   } status_type;

   typedef struct packed {
      logic                       usable;
      logic [2:0][CHROMA_W-1:0]   chroma;
   } ref_entry_type;

   localparam int REF_ENTRY_W = $bits(ref_entry_type);

endpackage

`default_nettype wire

@@ design/ncc_req_if.sv @@
// ---------------------------------------------------------------------------
// ncc_req_if: request channel of the chromaticity classifier
// Valid/ready channel carrying one load or classify item.
// ---------------------------------------------------------------------------
`default_nettype none

interface ncc_req_if;
   import ncc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [REF_IDX_W-1:0] ref_index;
   logic [FIELD_W-1:0]   red;
   logic [FIELD_W-1:0]   green;
   logic [FIELD_W-1:0]   blue;

   modport source (output valid, action, ref_index, red, green, blue, input ready);
   modport sink   (input valid, action, ref_index, red, green, blue, output ready);

endinterface

`default_nettype wire

@@ design/ncc_rsp_if.sv @@
// ---------------------------------------------------------------------------
// ncc_rsp_if: result channel of the chromaticity classifier
// Valid/ready channel carrying one classification result item.
// ---------------------------------------------------------------------------
`default_nettype none

interface ncc_rsp_if;
   import ncc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [CLASS_W-1:0] class_index;
   status_type                status;
   logic [DIST_W-1:0]         best_dist_sq;
   logic [DIST_W-1:0]         second_dist_sq;

   modport source (output valid, class_index, status, best_dist_sq, second_dist_sq,
                    input ready);
   modport sink   (input valid, class_index, status, best_dist_sq, second_dist_sq,
                   output ready);

endinterface

`default_nettype wire

@@ design/ncc_ram.sv @@
// ---------------------------------------------------------------------------
// ncc_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered and held between reads.
// ---------------------------------------------------------------------------
`default_nettype none

module ncc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/nearest_chromaticity_classifier_unit.sv @@
// ---------------------------------------------------------------------------
// nearest_chromaticity_classifier_unit: nearest reference colour by chromaticity
//
// Items arrive on req_ch. A load item (action 0) normalises its colour and
// stores it as reference entry ref_index; it gives no result. A classify item
// (action 1) normalises the live colour, scans the first ref_count entries
// (at most 16) and gives one result item on rsp_ch: class index, status and
// the best and runner-up squared distances.
// One restoring divider yields one quotient bit a cycle, 17 bits per channel,
// and normalises a colour one channel after another. One shared multiplier then
// squares one channel difference a cycle; each entry goes through read, three
// squares, accumulate and compare, and the limit test follows in ST_LIM_A to ST_LIM_E.
// A load of a zero-sum colour skips the divider; a classify of a zero-sum live
// colour skips both the divider and the scan.
// req_ch.ready is high only while the block is idle. The result sits in an
// output register, so the next item is taken while it waits; a stalled
// receiver holds the block only when a second result is ready to leave.
// Reset clears the registers csr_* write and the control state; the
// reference table holds nothing valid until entries are loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_chromaticity_classifier_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ncc_req_if.sink                              req_ch,
   ncc_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [ncc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ncc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ncc_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_DIV   = 12'b0000_0000_0010,
      ST_WRITE = 12'b0000_0000_0100,
      ST_READ  = 12'b0000_0000_1000,
      ST_SQ    = 12'b0000_0001_0000,
      ST_ACC   = 12'b0000_0010_0000,
      ST_LIM_A = 12'b0000_0100_0000,
      ST_LIM_B = 12'b0000_1000_0000,
      ST_LIM_C = 12'b0001_0000_0000,
      ST_LIM_D = 12'b0010_0000_0000,
      ST_LIM_E = 12'b0100_0000_0000,
      ST_OUT   = 12'b1000_0000_0000
   } state_type;

   // control
   state_type               state_ff, state_in;
   logic [1:0]              ch_ff, ch_in;
   logic [DIV_STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic [COUNT_W-1:0]      n_ff, n_in;
   logic                    found_ff, found_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [COUNT_W-1:0]      ref_count_ff, ref_count_in;
   logic [ABS_W-1:0]        abs_max_ff, abs_max_in;
   logic [RATIO_W-1:0]      ratio_max_ff, ratio_max_in;

   // payload
   logic                          action_ff, action_in;
   logic [REF_IDX_W-1:0]          index_ff, index_in;
   logic [2:0][CHANNEL_BITS-1:0]  rgb_ff, rgb_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [SUM_W-1:0]              rem_ff, rem_in;
   logic [CHROMA_W-1:0]           quo_ff, quo_in;
   logic [2:0][CHROMA_W-1:0]      chr_ff, chr_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [DIST_W-1:0]             acc_ff, acc_in;
   logic [DIST_W-1:0]             best_ff, best_in;
   logic [DIST_W-1:0]             second_ff, second_in;
   logic [REF_IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic                          abs_ok_ff, abs_ok_in;
   logic [MUL_A_W-1:0]            rsq_ff, rsq_in;
   logic [PROD_W-1:0]             lo_ff, lo_in;
   logic signed [CLASS_W-1:0]     res_class_ff, res_class_in;
   status_type                    res_status_ff, res_status_in;
   logic signed [CLASS_W-1:0]     out_class_ff, out_class_in;
   status_type                    out_status_ff, out_status_in;
   logic [DIST_W-1:0]             out_best_ff, out_best_in;
   logic [DIST_W-1:0]             out_second_ff, out_second_in;

   // datapath nets
   logic                    req_accept;
   logic                    out_load;
   logic [SUM_W:0]          trial;
   logic                    trial_ge;
   logic [CHROMA_W-1:0]     live_c;
   logic [CHROMA_W-1:0]     ref_c;
   logic [CHROMA_W-1:0]     diff;
   logic [MUL_A_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [DIST_W-1:0]       dist_sum;
   logic [COUNT_W-1:0]      cnt_next;
   logic [WIDE_W-1:0]       ratio_lhs;
   logic [WIDE_W-1:0]       ratio_rhs;
   logic                    ratio_ok;

   // reference table
   logic                    ram_wr_en;
   ref_entry_type           wr_entry;
   logic                    ram_rd_en;
   logic [REF_ENTRY_W-1:0]  ram_rd_data;
   ref_entry_type           rd_entry;

   ncc_ram #(
      .WIDTH (REF_ENTRY_W),
      .DEPTH (REF_DEPTH)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (index_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff[REF_IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rd_entry        = ref_entry_type'(ram_rd_data);
   assign wr_entry.usable = (sum_ff != '0);
   assign wr_entry.chroma = chr_ff;
   assign ram_wr_en       = (state_ff == ST_WRITE);
   assign ram_rd_en       = (state_ff == ST_READ);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   // restoring divider step: the first step of a channel starts from the numerator
   assign trial    = (step_ff == '0) ? (SUM_W+1)'(rgb_ff[ch_ff]) : {rem_ff, 1'b0};
   assign trial_ge = (trial >= {1'b0, sum_ff});

   assign live_c = chr_ff[ch_ff];
   assign ref_c  = rd_entry.chroma[ch_ff];
   assign diff   = (live_c > ref_c) ? (live_c - ref_c) : (ref_c - live_c);

   assign dist_sum = acc_ff + prod_ff[DIST_W-1:0];
   assign cnt_next = cnt_ff + COUNT_W'(1);

   // best * 2^24 against second * ratio^2, from the two partial products
   assign ratio_lhs = {best_ff, MUL_A_W'(0)};
   assign ratio_rhs = {prod_ff, SPLIT_W'(0)} + WIDE_W'(lo_ff);
   assign ratio_ok  = (ratio_max_ff >= RATIO_ONE) || (ratio_lhs <= ratio_rhs);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ: begin
            mul_a = MUL_A_W'(diff);
            mul_b = diff;
         end
         ST_LIM_A: begin
            mul_a = MUL_A_W'(abs_max_ff);
            mul_b = abs_max_ff;
         end
         ST_LIM_B: begin
            mul_a = MUL_A_W'(ratio_max_ff[RATIO_FRAC-1:0]);
            mul_b = MUL_B_W'(ratio_max_ff[RATIO_FRAC-1:0]);
         end
         ST_LIM_C: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = second_ff[SPLIT_W-1:0];
         end
         ST_LIM_D: begin
            mul_a = rsq_ff;
            mul_b = second_ff[DIST_W-1:SPLIT_W];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // configuration writes
   always_comb begin
      ref_count_in = ref_count_ff;
      abs_max_in   = abs_max_ff;
      ratio_max_in = ratio_max_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REF_COUNT:    ref_count_in = csr_wdata[COUNT_W-1:0];
            CSR_ABS_MAX_DIST: abs_max_in   = csr_wdata[ABS_W-1:0];
            CSR_RATIO_MAX:    ratio_max_in = csr_wdata[RATIO_W-1:0];
            default: begin
               ref_count_in = ref_count_ff;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      found_in      = found_ff;
      action_in     = action_ff;
      index_in      = index_ff;
      rgb_in        = rgb_ff;
      sum_in        = sum_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      chr_in        = chr_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      second_in     = second_ff;
      best_idx_in   = best_idx_ff;
      abs_ok_in     = abs_ok_ff;
      rsq_in        = rsq_ff;
      lo_in         = lo_ff;
      res_class_in  = res_class_ff;
      res_status_in = res_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_ch.action;
               index_in  = req_ch.ref_index;
               rgb_in[0] = req_ch.red[CHANNEL_BITS-1:0];
               rgb_in[1] = req_ch.green[CHANNEL_BITS-1:0];
               rgb_in[2] = req_ch.blue[CHANNEL_BITS-1:0];
               sum_in    = SUM_W'(rgb_in[0]) + SUM_W'(rgb_in[1]) + SUM_W'(rgb_in[2]);
               ch_in     = '0;
               step_in   = '0;
               cnt_in    = '0;
               n_in      = (ref_count_ff > COUNT_W'(REF_DEPTH)) ? COUNT_W'(REF_DEPTH)
                                                                 : ref_count_ff;
               best_in   = DIST_INF;
               second_in = DIST_INF;
               found_in  = 1'b0;
               if (sum_in == '0) begin
                  state_in = (req_ch.action == ACTION_LOAD) ? ST_WRITE : ST_LIM_A;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            rem_in = trial_ge ? SUM_W'(trial - {1'b0, sum_ff}) : SUM_W'(trial);
            quo_in = {quo_ff[CHROMA_W-2:0], trial_ge};
            if (step_ff == DIV_STEP_W'(CHROMA_W - 1)) begin
               chr_in[ch_ff] = quo_in;
               step_in       = '0;
               if (ch_ff == 2'd2) begin
                  ch_in = '0;
                  if (action_ff == ACTION_LOAD) begin
                     state_in = ST_WRITE;
                  end else if (n_ff == '0) begin
                     state_in = ST_LIM_A;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end else begin
               step_in = step_ff + DIV_STEP_W'(1);
            end
         end

         ST_WRITE: begin
            state_in = ST_IDLE;
         end

         ST_READ: begin
            ch_in    = '0;
            state_in = ST_SQ;
         end

         ST_SQ: begin
            // the product of the previous channel comes from the multiplier's output register
            if (ch_ff == 2'd1) begin
               acc_in = prod_ff[DIST_W-1:0];
            end else if (ch_ff == 2'd2) begin
               acc_in = dist_sum;
            end
            if (ch_ff == 2'd2) begin
               ch_in    = '0;
               state_in = ST_ACC;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end

         ST_ACC: begin
            if (rd_entry.usable) begin
               if (dist_sum < best_ff) begin
                  second_in   = best_ff;
                  best_in     = dist_sum;
                  best_idx_in = cnt_ff[REF_IDX_W-1:0];
                  found_in    = 1'b1;
               end else if (dist_sum < second_ff) begin
                  second_in = dist_sum;
               end
            end
            cnt_in   = cnt_next;
            state_in = (cnt_next < n_ff) ? ST_READ : ST_LIM_A;
         end

         ST_LIM_A: begin
            state_in = ST_LIM_B;
         end

         ST_LIM_B: begin
            abs_ok_in = (best_ff <= prod_ff[DIST_W-1:0]);
            state_in  = ST_LIM_C;
         end

         ST_LIM_C: begin
            rsq_in   = prod_ff[MUL_A_W-1:0];
            state_in = ST_LIM_D;
         end

         ST_LIM_D: begin
            lo_in    = prod_ff;
            state_in = ST_LIM_E;
         end

         ST_LIM_E: begin
            res_class_in = NO_MATCH_INDEX;
            if (!found_ff) begin
               res_status_in = STATUS_NO_REF;
            end else if ((second_ff == DIST_INF) || (second_ff == '0)) begin
               res_status_in = STATUS_NO_RUNNER;
            end else if (abs_ok_ff && ratio_ok) begin
               res_status_in = STATUS_MATCH;
               res_class_in  = $signed({1'b0, best_idx_ff});
            end else begin
               res_status_in = STATUS_LIMIT;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            // hold until the output register is free
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_class_in  = out_class_ff;
      out_status_in = out_status_ff;
      out_best_in   = out_best_ff;
      out_second_in = out_second_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         out_class_in  = res_class_ff;
         out_status_in = res_status_ff;
         out_best_in   = best_ff;
         out_second_in = second_ff;
      end else if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.class_index    = out_class_ff;
   assign rsp_ch.status         = out_status_ff;
   assign rsp_ch.best_dist_sq   = out_best_ff;
   assign rsp_ch.second_dist_sq = out_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ref_count_ff <= '0;
         abs_max_ff   <= '0;
         ratio_max_ff <= '0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         ref_count_ff <= ref_count_in;
         abs_max_ff   <= abs_max_in;
         ratio_max_ff <= ratio_max_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      index_ff      <= index_in;
      rgb_ff        <= rgb_in;
      sum_ff        <= sum_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      chr_ff        <= chr_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      best_ff       <= best_in;
      second_ff     <= second_in;
      best_idx_ff   <= best_idx_in;
      abs_ok_ff     <= abs_ok_in;
      rsq_ff        <= rsq_in;
      lo_ff         <= lo_in;
      res_class_ff  <= res_class_in;
      res_status_ff <= res_status_in;
      out_class_ff  <= out_class_in;
      out_status_ff <= out_status_in;
      out_best_ff   <= out_best_in;
      out_second_ff <= out_second_in;
   end

endmodule

`default_nettype wire
